// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file of the core, pesdf_checker.sv.
// Self-contained; no other file is needed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define PESDF_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PESDF_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pesdf_pkg.sv =====
// Package for the PES packet deframer: widths, header offsets and the result struct.
// No dependencies.
`timescale 1ns / 1ps

package pesdf_pkg;

    localparam int BYTE_W = 8;
    localparam int OFF_W  = 17;
    localparam int PTS_W  = 33;

    // Start-code prefix bytes (the fourth byte is the configured stream id)
    localparam logic [BYTE_W-1:0] PREFIX_ZERO     = 8'h00;
    localparam logic [BYTE_W-1:0] PREFIX_SYNC     = 8'h01;
    localparam logic [BYTE_W-1:0] STREAM_ID_RESET = 8'hBD;

    // Offsets within a packet
    localparam logic [OFF_W-1:0] OFF_START  = 17'd0;
    localparam logic [OFF_W-1:0] OFF_SYNC   = 17'd2;
    localparam logic [OFF_W-1:0] OFF_SID    = 17'd3;
    localparam logic [OFF_W-1:0] PREFIX_LEN = 17'd4;
    localparam logic [OFF_W-1:0] OFF_LEN_HI = 17'd4;
    localparam logic [OFF_W-1:0] OFF_LEN_LO = 17'd5;
    localparam logic [OFF_W-1:0] OFF_FLAGS  = 17'd7;
    localparam logic [OFF_W-1:0] OFF_PTS0   = 17'd9;
    localparam logic [OFF_W-1:0] OFF_PTS1   = 17'd10;
    localparam logic [OFF_W-1:0] OFF_PTS2   = 17'd11;
    localparam logic [OFF_W-1:0] OFF_PTS3   = 17'd12;
    localparam logic [OFF_W-1:0] OFF_PTS4   = 17'd13;

    localparam logic [OFF_W-1:0] HEADER_LEN     = 17'd6;
    localparam logic [OFF_W-1:0] TIME_MIN_TOTAL = 17'd14;

    // Result buffer depth
    localparam logic [1:0] RES_FIFO_DEPTH = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [OFF_W-1:0]  byte_offset;
        logic              last_byte;
        logic              time_valid;
        logic [PTS_W-1:0]  presentation_time;
    } result_t;

endpackage

// ===== rtl/core/pesdf_if.sv =====
// Valid/ready channel interfaces of the deframer: input bytes, config, results.
// Depends on pesdf_pkg.
`timescale 1ns / 1ps

interface pesdf_byte_if;
    import pesdf_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface pesdf_cfg_if;
    import pesdf_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] stream_id;

    modport source (output valid, output stream_id, input ready);
    modport sink (input valid, input stream_id, output ready);
endinterface

interface pesdf_result_if;
    import pesdf_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic [OFF_W-1:0]  byte_offset;
    logic              last_byte;
    logic              time_valid;
    logic [PTS_W-1:0]  presentation_time;

    modport source (output valid, output out_byte, output byte_offset, output last_byte,
                    output time_valid, output presentation_time, input ready);
    modport sink (input valid, input out_byte, input byte_offset, input last_byte,
                  input time_valid, input presentation_time, output ready);
endinterface

// ===== rtl/core/pesdf_parser.sv =====
// Input byte register, packet parse logic and packet state registers.
// Depends on pesdf_pkg and pesdf_if.
`timescale 1ns / 1ps

module pesdf_parser (
    input  logic              clk,
    input  logic              rst_n,
    pesdf_byte_if.sink        byte_in,
    pesdf_cfg_if.sink         cfg,
    input  logic              res_room,
    output logic              res_valid,
    output pesdf_pkg::result_t res
);
    import pesdf_pkg::*;

    logic [BYTE_W-1:0] stream_id_reg;
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic [OFF_W-1:0]  pos_reg;
    logic [OFF_W-1:0]  total_reg;
    logic [BYTE_W-1:0] len_hi_reg;
    logic              flag_reg;
    logic [PTS_W-1:0]  accum_reg;

    logic [OFF_W-1:0]  pos_next;
    logic [OFF_W-1:0]  total_next;
    logic [BYTE_W-1:0] len_hi_next;
    logic              flag_next;
    logic [PTS_W-1:0]  accum_next;

    logic [OFF_W-1:0]  off;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] expect_byte;
    logic              in_prefix;
    logic              mismatch;
    logic              last;
    logic              tvalid;
    logic              advance;

    assign off     = pos_reg;
    assign b       = in_byte_reg;
    assign advance = in_valid_reg && res_room;

    assign byte_in.ready = !in_valid_reg || res_room;
    assign cfg.ready     = 1'b1;

    // Expected prefix byte and mismatch detect
    always_comb
    begin
        if (off == OFF_SYNC)
        begin
            expect_byte = PREFIX_SYNC;
        end
        else if (off == OFF_SID)
        begin
            expect_byte = stream_id_reg;
        end
        else
        begin
            expect_byte = PREFIX_ZERO;
        end
        in_prefix = off < PREFIX_LEN;
        mismatch  = in_prefix && (b != expect_byte);
    end

    // Per-byte packet state update
    always_comb
    begin
        total_next  = total_reg;
        len_hi_next = len_hi_reg;
        flag_next   = flag_reg;
        accum_next  = accum_reg;
        last        = 1'b0;
        if (in_prefix)
        begin
            if (off == OFF_START)
            begin
                flag_next  = 1'b0;
                accum_next = '0;
                total_next = '0;
            end
        end
        else if (off == OFF_LEN_HI)
        begin
            len_hi_next = b;
        end
        else if (off == OFF_LEN_LO)
        begin
            total_next = {1'b0, len_hi_reg, b} + HEADER_LEN;
            last       = (total_next == HEADER_LEN);
        end
        else
        begin
            case (off)
                OFF_FLAGS: flag_next  = b[7];
                OFF_PTS0:  accum_next = {b[3:1], 30'd0};
                OFF_PTS1:  accum_next = accum_reg | {3'd0, b, 22'd0};
                OFF_PTS2:  accum_next = accum_reg | {11'd0, b[7:1], 15'd0};
                OFF_PTS3:  accum_next = accum_reg | {18'd0, b, 7'd0};
                OFF_PTS4:  accum_next = accum_reg | {26'd0, b[7:1]};
                default:   accum_next = accum_reg;
            endcase
            last = (off + 17'd1) >= total_reg;
        end
        tvalid   = last && flag_next && (total_next >= TIME_MIN_TOTAL);
        pos_next = (mismatch || last) ? '0 : off + 17'd1;
    end

    // Result toward the output buffer; a prefix mismatch drops the byte
    always_comb
    begin
        res_valid             = in_valid_reg && !mismatch;
        res.out_byte          = b;
        res.byte_offset       = off;
        res.last_byte         = last;
        res.time_valid        = tvalid;
        res.presentation_time = tvalid ? accum_next : '0;
    end

    // Config register and input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_id_reg <= STREAM_ID_RESET;
            in_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                stream_id_reg <= cfg.stream_id;
            end
            if (byte_in.valid && byte_in.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.valid && byte_in.ready)
        begin
            in_byte_reg <= byte_in.data_byte;
        end
    end

    // Packet state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            total_reg  <= '0;
            len_hi_reg <= '0;
            flag_reg   <= 1'b0;
            accum_reg  <= '0;
        end
        else if (advance)
        begin
            pos_reg <= pos_next;
            if (!mismatch)
            begin
                total_reg  <= total_next;
                len_hi_reg <= len_hi_next;
                flag_reg   <= flag_next;
                accum_reg  <= accum_next;
            end
        end
    end

endmodule

// ===== rtl/core/pesdf_result_fifo.sv =====
// Two-entry result buffer that decouples the parser from output backpressure.
// Depends on pesdf_pkg and pesdf_if.
`timescale 1ns / 1ps

module pesdf_result_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_valid,
    input  pesdf_pkg::result_t wr_data,
    output logic               room,
    pesdf_result_if.source     result_out
);
    import pesdf_pkg::*;

    result_t    entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;
    result_t    head;

    assign room = count_reg != RES_FIFO_DEPTH;
    assign push = wr_valid && room;
    assign pop  = result_out.valid && result_out.ready;
    assign head = entry_reg[rd_ptr_reg];

    // Output side
    assign result_out.valid             = count_reg != 2'd0;
    assign result_out.out_byte          = head.out_byte;
    assign result_out.byte_offset       = head.byte_offset;
    assign result_out.last_byte         = head.last_byte;
    assign result_out.time_valid        = head.time_valid;
    assign result_out.presentation_time = head.presentation_time;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Payload storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/core/pes_packet_deframer_core.sv =====
// PES packet deframer top level: prefix match, length tracking, PTS extraction.
// A byte reaches the result channel through the input register and then the result buffer.
// Throughput: one byte per cycle while the result buffer has room; single-pass parse.
// A prefix mismatch consumes its byte and produces no result.
// Reset (rst_n, async, active low) clears packet state and buffers; stream id returns to 0xBD.
// Depends on pesdf_pkg, pesdf_if, pesdf_parser, pesdf_result_fifo.
`timescale 1ns / 1ps

module pes_packet_deframer_core (
    input  logic           clk,
    input  logic           rst_n,
    pesdf_byte_if.sink     byte_in,
    pesdf_cfg_if.sink      cfg,
    pesdf_result_if.source result_out
);
    import pesdf_pkg::*;

    logic    res_valid;
    logic    res_room;
    result_t res;

    // Parse stage
    pesdf_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_in),
        .cfg       (cfg),
        .res_room  (res_room),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output buffer
    pesdf_result_fifo u_result_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_valid   (res_valid),
        .wr_data    (res),
        .room       (res_room),
        .result_out (result_out)
    );

endmodule

// ===== rtl/core/pesdf_checker.sv =====
// Port-level assertions for the deframer core, attached by a bind statement.
// Depends on pesdf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pesdf_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [pesdf_pkg::BYTE_W-1:0]       out_byte,
    input logic [pesdf_pkg::OFF_W-1:0]        byte_offset,
    input logic                               last_byte,
    input logic                               time_valid,
    input logic [pesdf_pkg::PTS_W-1:0]        presentation_time
);
    import pesdf_pkg::*;

    // A time is only reported on the final byte of a packet
    `PESDF_ASSERT_IMP(a_time_on_last, clk, rst_n, out_valid && time_valid, last_byte, "time_valid without last_byte")

    // Without a valid time the stamp field stays zero
    `PESDF_ASSERT_IMP(a_pts_zero, clk, rst_n, out_valid && !time_valid, presentation_time == '0, "stale presentation_time")

    // Forwarded bytes at OFF_START and OFF_SYNC carry their start-code values
    `PESDF_ASSERT_IMP(a_prefix_bytes, clk, rst_n, out_valid && (byte_offset == OFF_START || byte_offset == OFF_SYNC), out_byte == ((byte_offset == OFF_SYNC) ? PREFIX_SYNC : PREFIX_ZERO), "bad prefix byte")

    // No packet ends before its length field is complete
    `PESDF_ASSERT_IMP(a_no_early_last, clk, rst_n, out_valid && (byte_offset < OFF_LEN_LO), !last_byte, "last_byte inside header")

    // A stalled result is not withdrawn
    `PESDF_ASSERT_NXT(a_hold_valid, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped under backpressure")

endmodule

bind pes_packet_deframer_core pesdf_checker u_pesdf_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (result_out.valid),
    .out_ready         (result_out.ready),
    .out_byte          (result_out.out_byte),
    .byte_offset       (result_out.byte_offset),
    .last_byte         (result_out.last_byte),
    .time_valid        (result_out.time_valid),
    .presentation_time (result_out.presentation_time)
);

// ===== dv/pesdf_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the PES packet deframer: predicts one result per forwarded byte
// and compares it field by field with the result channel. Depends on pesdf_pkg, pesdf_if.

module pesdf_result_checker (
    input  logic    clk,
    input  logic    rst_n,
    pesdf_byte_if   byte_mon,
    pesdf_cfg_if    cfg_mon,
    pesdf_result_if res_mon,
    output int      fail_count,
    output int      pending_count
);
    import pesdf_pkg::*;

    localparam int MAX_REPORTS = 10;

    // Shadow of the parser state and the stream id register
    logic [BYTE_W-1:0] sid_copy  = STREAM_ID_RESET;
    logic [OFF_W-1:0]  next_off  = '0;
    logic [OFF_W-1:0]  pkt_total = '0;
    logic [BYTE_W-1:0] len_hi    = '0;
    logic              pts_flag  = 1'b0;
    logic [PTS_W-1:0]  pts_acc   = '0;

    // Results owed by the block, oldest first
    result_t pending_results[$];

    initial
    begin
        fail_count    = 0;
        pending_count = 0;
    end

    function automatic logic [BYTE_W-1:0] start_code_at(logic [OFF_W-1:0] off);
        if (off == OFF_SYNC)
            return PREFIX_SYNC;
        if (off == OFF_SID)
            return sid_copy;
        return PREFIX_ZERO;
    endfunction

    // Advance the shadow parser by one byte; queue the result it produces, if any
    task automatic parse_byte(input logic [BYTE_W-1:0] b);
        logic [OFF_W-1:0] off;
        logic             last;
        result_t          r;
        off  = next_off;
        last = 1'b0;
        if (off < PREFIX_LEN)
        begin
            // wrong start-code byte: drop it, hunt again from the next one
            if (b != start_code_at(off))
            begin
                next_off = OFF_START;
                return;
            end
            if (off == OFF_START)
            begin
                pts_flag  = 1'b0;
                pts_acc   = '0;
                pkt_total = '0;
            end
        end
        else if (off == OFF_LEN_HI)
        begin
            len_hi = b;
        end
        else if (off == OFF_LEN_LO)
        begin
            pkt_total = {1'b0, len_hi, b} + HEADER_LEN;
            last      = (pkt_total == HEADER_LEN);
        end
        else
        begin
            case (off)
                OFF_FLAGS: pts_flag = b[7];
                OFF_PTS0:  pts_acc  = PTS_W'(b[3:1]) << 30;
                OFF_PTS1:  pts_acc  = pts_acc | (PTS_W'(b) << 22);
                OFF_PTS2:  pts_acc  = pts_acc | (PTS_W'(b[7:1]) << 15);
                OFF_PTS3:  pts_acc  = pts_acc | (PTS_W'(b) << 7);
                OFF_PTS4:  pts_acc  = pts_acc | PTS_W'(b[7:1]);
                default:   ;
            endcase
            if (({1'b0, off} + 18'd1) >= {1'b0, pkt_total})
                last = 1'b1;
        end

        r.out_byte          = b;
        r.byte_offset       = off;
        r.last_byte         = last;
        r.time_valid        = last && pts_flag && (pkt_total >= TIME_MIN_TOTAL);
        r.presentation_time = r.time_valid ? pts_acc : '0;
        next_off            = last ? OFF_START : off + 17'd1;
        pending_results.push_back(r);
    endtask

    task automatic note_failure(input string what, input logic [63:0] want_v,
                                input logic [63:0] got_v);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want_v, got_v);
    endtask

    // Compare an accepted result with the oldest one owed
    task automatic check_result();
        result_t want;
        if (pending_results.size() == 0)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: result with none pending: byte 0x%0h offset %0d",
                         $time, res_mon.out_byte, res_mon.byte_offset);
            return;
        end
        want = pending_results.pop_front();
        if (res_mon.out_byte !== want.out_byte)
            note_failure("out_byte", 64'(want.out_byte), 64'(res_mon.out_byte));
        if (res_mon.byte_offset !== want.byte_offset)
            note_failure("byte_offset", 64'(want.byte_offset), 64'(res_mon.byte_offset));
        if (res_mon.last_byte !== want.last_byte)
            note_failure("last_byte", 64'(want.last_byte), 64'(res_mon.last_byte));
        if (res_mon.time_valid !== want.time_valid)
            note_failure("time_valid", 64'(want.time_valid), 64'(res_mon.time_valid));
        if (res_mon.presentation_time !== want.presentation_time)
            note_failure("presentation_time", 64'(want.presentation_time),
                         64'(res_mon.presentation_time));
    endtask

    // Watch all three channels at each rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_mon.valid && cfg_mon.ready)
                sid_copy = cfg_mon.stream_id;
            if (byte_mon.valid && byte_mon.ready)
                parse_byte(byte_mon.data_byte);
            if (res_mon.valid && res_mon.ready)
                check_result();
            pending_count = pending_results.size();
        end
    end

endmodule

// ===== dv/pes_packet_deframer_core_test.sv =====
`timescale 1ns / 1ps
// Top of the PES packet deframer test: clock, reset, byte and stream id stimulus,
// result back-pressure and verdict. Depends on pesdf_pkg, pesdf_if, pesdf_result_checker.

module pes_packet_deframer_core_test;
    import pesdf_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 8;
    localparam int TAIL_CYCLES  = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 190;
    localparam int NUM_PHASES   = 5;
    localparam int DIR_LEN      = 30;
    localparam int LONG_LEN     = 100;

    typedef enum int {GRP_PACKET, GRP_BROKEN, GRP_NOISE} group_t;

    // zero-length packet, a mismatch at each start-code byte, a 14-byte packet with time
    localparam logic [BYTE_W-1:0] DIRECTED [DIR_LEN] = '{
        8'h00, 8'h00, 8'h01, STREAM_ID_RESET, 8'h00, 8'h00,
        8'h05,
        8'h00, 8'h07,
        8'h00, 8'h00, 8'h02,
        8'h00, 8'h00, 8'h01, 8'hBE,
        8'h00, 8'h00, 8'h01, STREAM_ID_RESET, 8'h00, 8'h08,
        8'h80, 8'h80, 8'h05, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
    };

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;

    logic [BYTE_W-1:0] cur_sid    = STREAM_ID_RESET;
    int                fwd_items  = 0;
    bit                tx_idle_on = 1'b1;
    bit                tx_nogap   = 1'b0;
    bit                rx_idle_on = 1'b1;
    bit                rx_free    = 1'b0;
    bit                hold_go    = 1'b0;
    bit                hold_done  = 1'b0;
    bit                hold_req   = 1'b0;

    pesdf_byte_if   byte_if ();
    pesdf_cfg_if    cfg_if ();
    pesdf_result_if res_if ();

    pes_packet_deframer_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_if),
        .cfg        (cfg_if),
        .result_out (res_if)
    );

    pesdf_result_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_mon      (byte_if),
        .cfg_mon       (cfg_if),
        .res_mon       (res_if),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #CLK_HALF clk = ~clk;

    function automatic logic [BYTE_W-1:0] start_code(int k);
        if (k == 2)
            return PREFIX_SYNC;
        if (k == 3)
            return cur_sid;
        return PREFIX_ZERO;
    endfunction

    // One byte request; called and returns at a falling edge, valid left high
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = (tx_idle_on && !tx_nogap) ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            byte_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_if.valid     <= 1'b1;
        byte_if.data_byte <= b;
        do @(posedge clk); while (!byte_if.ready);
        @(negedge clk);
    endtask

    // Well-formed packet with random header and payload content
    task automatic send_packet(input logic [15:0] len, input bit flag);
        logic [BYTE_W-1:0] b;
        for (int i = 0; i < int'(len) + 6; i++)
        begin
            if (i < 4)
                b = start_code(i);
            else if (i == 4)
                b = len[15:8];
            else if (i == 5)
                b = len[7:0];
            else if (i == 7)
                b = {flag, 7'($urandom)};
            else
                b = 8'($urandom);
            send_byte(b);
        end
        fwd_items += int'(len) + 6;
    endtask

    // Partial start code ended by a wrong byte
    task automatic send_broken_prefix();
        int                k;
        logic [BYTE_W-1:0] w;
        k = $urandom_range(0, 3);
        for (int i = 0; i < k; i++)
            send_byte(start_code(i));
        do w = 8'($urandom); while (w == start_code(k));
        send_byte(w);
    endtask

    // Zero-heavy junk that never completes a start code and ends back in hunt
    task automatic send_noise();
        int                n;
        logic [BYTE_W-1:0] b;
        n = $urandom_range(1, 8);
        repeat (n)
        begin
            b = ($urandom_range(0, 2) == 0) ? PREFIX_ZERO : 8'($urandom);
            if (b == PREFIX_SYNC)
                b = 8'h02;
            send_byte(b);
        end
        send_byte(8'($urandom_range(2, 255)));
    endtask

    // Let every owed result arrive, then cover bytes that produce none
    task automatic drain();
        byte_if.valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    task automatic write_sid(input logic [BYTE_W-1:0] v);
        drain();
        cfg_if.valid     <= 1'b1;
        cfg_if.stream_id <= v;
        do @(posedge clk); while (!cfg_if.ready);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
        cur_sid = v;
    endtask

    // Stimulus and verdict
    initial
    begin : stimulus
        logic [BYTE_W-1:0] phase_sid [NUM_PHASES];
        int                target;
        int                pick;
        group_t            grp;
        byte_if.valid     = 1'b0;
        byte_if.data_byte = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.stream_id  = '0;
        res_if.ready      = 1'b0;
        rst_n             = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // directed bytes under the reset stream id
        foreach (DIRECTED[i])
            send_byte(DIRECTED[i]);

        phase_sid = '{8'h00, 8'hFF, 8'hE0, 8'($urandom), STREAM_ID_RESET};
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_sid(phase_sid[p]);
            if (p == 0)
            begin
                // back-to-back bytes while the result side holds off
                tx_nogap = 1'b1;
                hold_go  = 1'b1;
            end
            target = fwd_items + PHASE_ITEMS;
            while (fwd_items < target)
            begin
                if (hold_done)
                    tx_nogap = 1'b0;
                if ($urandom_range(0, 7) == 0)
                    tx_idle_on = !tx_idle_on;
                pick = $urandom_range(0, 19);
                grp  = (pick < 14) ? GRP_PACKET : (pick < 17) ? GRP_BROKEN : GRP_NOISE;
                case (grp)
                    GRP_PACKET:
                    begin
                        if ($urandom_range(0, 15) == 0)
                            send_packet(16'($urandom_range(25, 300)), 1'($urandom));
                        else
                            send_packet(16'($urandom_range(0, 24)), 1'($urandom));
                    end
                    GRP_BROKEN: send_broken_prefix();
                    GRP_NOISE:  send_noise();
                    default:    ;
                endcase
            end
        end

        // long packet with time, both sides streaming
        drain();
        tx_nogap = 1'b1;
        rx_free  = 1'b1;
        send_packet(16'(LONG_LEN), 1'b1);
        drain();
        tx_nogap = 1'b0;
        rx_free  = 1'b0;

        if (fail_count == 0 && pending_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Long result hold-off, counted here
    initial
    begin : result_hold
        wait (hold_go);
        hold_req = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req  = 1'b0;
        hold_done = 1'b1;
    end

    // Result side: random stall before each result, stretches without stalls
    initial
    begin : result_sink
        int gap;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = (rx_idle_on && !rx_free) ? $urandom_range(0, 14) : 0;
            if (gap > 0 || hold_req)
            begin
                res_if.ready <= 1'b0;
                repeat (gap) @(negedge clk);
                while (hold_req)
                    @(negedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (!res_if.valid);
            @(negedge clk);
            if ($urandom_range(0, 63) == 0)
                rx_idle_on = !rx_idle_on;
        end
    end

    // Run limit
    initial
    begin : run_limit
        #10ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
